@@ rtl/core/cstr_pkg.sv @@
package cstr_pkg;

  // What a result item carries: a kept source byte or one of the two errors.
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_STRAY  = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_e;

  localparam int unsigned OUT_LINE_W = 32;

  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              data;
    logic [OUT_LINE_W-1:0]   line;
  } result_t;

  // One input byte gives at most two results; cnt holds how many (0 to 2).
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

endpackage

@@ rtl/core/cstr_scan.sv @@
module cstr_scan #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output cstr_pkg::res_pair_t pair_o
);
  import cstr_pkg::*;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_LIT   = 2'd1,
    MODE_LINE  = 2'd2,
    MODE_BLOCK = 2'd3
  } mode_e;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  mode_e                mode_q, mode_d;
  logic                 quote_sq_q, quote_sq_d;
  logic                 held_slash_q, held_slash_d;
  logic                 held_star_q, held_star_d;
  logic                 after_bs_q, after_bs_d;
  logic                 stopped_q, stopped_d;
  logic [LINE_BITS-1:0] cur_line_q, cur_line_d;
  logic [LINE_BITS-1:0] open_line_q, open_line_d;
  res_pair_t            pair;

  function automatic res_pair_t push(res_pair_t p, result_t r);
    res_pair_t q;
    q = p;
    if (p.cnt == 2'd0) begin
      q.r0 = r;
    end else begin
      q.r1 = r;
    end
    q.cnt = p.cnt + 2'd1;
    return q;
  endfunction

  function automatic result_t text_res(logic [7:0] b);
    result_t r;
    r.kind = KIND_TEXT;
    r.data = b;
    r.line = '0;
    return r;
  endfunction

  function automatic result_t err_res(kind_e k, logic [LINE_BITS-1:0] l);
    result_t r;
    r.kind = k;
    r.data = '0;
    r.line = OUT_LINE_W'(l);
    return r;
  endfunction

  always_comb begin
    logic run_plain;
    mode_d       = mode_q;
    quote_sq_d   = quote_sq_q;
    held_slash_d = held_slash_q;
    held_star_d  = held_star_q;
    after_bs_d   = after_bs_q;
    stopped_d    = stopped_q;
    cur_line_d   = cur_line_q;
    open_line_d  = open_line_q;
    pair         = '0;
    run_plain    = 1'b0;

    if (!stopped_q) begin
      unique case (mode_q)
        MODE_CODE: begin
          if (held_slash_q) begin
            held_slash_d = 1'b0;
            if (byte_i == CH_SLASH) begin
              mode_d = MODE_LINE;
            end else if (byte_i == CH_STAR) begin
              mode_d      = MODE_BLOCK;
              open_line_d = cur_line_q;
              held_star_d = 1'b0;
            end else begin
              pair      = push(pair, text_res(CH_SLASH));
              run_plain = 1'b1;
            end
          end else if (held_star_q) begin
            held_star_d = 1'b0;
            if (byte_i == CH_SLASH) begin
              pair      = push(pair, err_res(KIND_STRAY, cur_line_q));
              stopped_d = 1'b1;
            end else begin
              pair      = push(pair, text_res(CH_STAR));
              run_plain = 1'b1;
            end
          end else begin
            run_plain = 1'b1;
          end
        end
        MODE_LIT: begin
          pair = push(pair, text_res(byte_i));
          if (after_bs_q) begin
            after_bs_d = 1'b0;
          end else if (byte_i == CH_BSLASH) begin
            after_bs_d = 1'b1;
          end else if (byte_i == (quote_sq_q ? CH_SQ : CH_DQ)) begin
            mode_d = MODE_CODE;
          end
          if (byte_i == CH_NL && cur_line_q != LINE_TOP) begin
            cur_line_d = cur_line_q + LINE_ONE;
          end
        end
        MODE_LINE: begin
          if (byte_i == CH_NL) begin
            pair   = push(pair, text_res(byte_i));
            mode_d = MODE_CODE;
            if (cur_line_q != LINE_TOP) begin
              cur_line_d = cur_line_q + LINE_ONE;
            end
          end
        end
        MODE_BLOCK: begin
          if (held_star_q && byte_i == CH_SLASH) begin
            held_star_d = 1'b0;
            mode_d      = MODE_CODE;
          end else begin
            held_star_d = (byte_i == CH_STAR);
            if (byte_i == CH_NL) begin
              pair = push(pair, text_res(byte_i));
              if (cur_line_q != LINE_TOP) begin
                cur_line_d = cur_line_q + LINE_ONE;
              end
            end
          end
        end
        default: begin
          mode_d = MODE_CODE;
        end
      endcase

      // A code byte with nothing held in front of it.
      if (run_plain) begin
        if (byte_i == CH_SLASH) begin
          held_slash_d = 1'b1;
        end else if (byte_i == CH_STAR) begin
          held_star_d = 1'b1;
        end else begin
          pair = push(pair, text_res(byte_i));
          if (byte_i == CH_DQ || byte_i == CH_SQ) begin
            mode_d     = MODE_LIT;
            quote_sq_d = (byte_i == CH_SQ);
            after_bs_d = 1'b0;
          end else if (byte_i == CH_NL && cur_line_q != LINE_TOP) begin
            cur_line_d = cur_line_q + LINE_ONE;
          end
        end
      end

      // End of text: flush a held byte, report an open block comment, or start afresh.
      if (last_i && !stopped_d) begin
        if (mode_d == MODE_BLOCK) begin
          pair      = push(pair, err_res(KIND_UNTERM, open_line_d));
          stopped_d = 1'b1;
        end else begin
          if (mode_d == MODE_CODE && held_slash_d) begin
            pair = push(pair, text_res(CH_SLASH));
          end else if (mode_d == MODE_CODE && held_star_d) begin
            pair = push(pair, text_res(CH_STAR));
          end
          mode_d       = MODE_CODE;
          quote_sq_d   = 1'b0;
          held_slash_d = 1'b0;
          held_star_d  = 1'b0;
          after_bs_d   = 1'b0;
          cur_line_d   = LINE_ONE;
          open_line_d  = LINE_ONE;
        end
      end
    end
  end

  assign pair_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_CODE;
      quote_sq_q   <= 1'b0;
      held_slash_q <= 1'b0;
      held_star_q  <= 1'b0;
      after_bs_q   <= 1'b0;
      stopped_q    <= 1'b0;
      cur_line_q   <= LINE_ONE;
      open_line_q  <= LINE_ONE;
    end else if (step_i) begin
      mode_q       <= mode_d;
      quote_sq_q   <= quote_sq_d;
      held_slash_q <= held_slash_d;
      held_star_q  <= held_star_d;
      after_bs_q   <= after_bs_d;
      stopped_q    <= stopped_d;
      cur_line_q   <= cur_line_d;
      open_line_q  <= open_line_d;
    end
  end

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("scanner left the stopped state without a reset");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> pair.cnt == 2'd0)
    else $error("scanner produced results after an error");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pair.cnt == 2'd2 |-> pair.r0.kind == KIND_TEXT)
    else $error("an error result was followed by another result");

endmodule

@@ rtl/core/cstr_obuf.sv @@
module cstr_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  cstr_pkg::res_pair_t pair_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output cstr_pkg::result_t   res_o,
  output logic                last_o
);
  import cstr_pkg::*;

  logic      res_v_q;
  logic      idx_q;
  res_pair_t pair_q;
  logic      is_last;

  assign is_last = (pair_q.cnt != 2'd2) || idx_q;
  assign free_o  = !res_v_q || (ready_i && is_last);
  assign valid_o = res_v_q;
  assign res_o   = idx_q ? pair_q.r1 : pair_q.r0;
  assign last_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load_i) begin
      res_v_q <= (pair_i.cnt != 2'd0);
      idx_q   <= 1'b0;
    end else if (res_v_q && ready_i) begin
      if (is_last) begin
        res_v_q <= 1'b0;
      end else begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_i;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register loaded while a result was still pending");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> pair_i.cnt != 2'd3)
    else $error("more than two results for one input byte");

endmodule

@@ rtl/core/comment_stripper.sv @@
// Comment stripper: removes line and block comments from a byte stream.
// An accepted request is held in the input register, scanned, and its results are
// loaded into the result register, from which they are handed out in order.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is ready; a byte with two results keeps the result register until both are out.
// Reset is asynchronous and active low: the scanner returns to plain code on line one.
module comment_stripper #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // in_byte [7:0]
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // out_byte [7:0], line_number [39:8]
  output logic [39:0] m_axis_tdata_o,
  // result_kind [1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);
  import cstr_pkg::*;

  // Input register: each accepted request waits here until the scanner steps on it.
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       advance;
  logic       out_free;
  res_pair_t  pair;
  result_t    res;

  // The registered byte moves on as soon as the result register can take
  // everything it produces, so a new request can enter in the same cycle.
  assign advance         = in_v_q && out_free;
  assign s_axis_tready_o = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Scanner: mode state, held characters and line counters, one byte per step.
  cstr_scan #(
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .pair_o (pair)
  );

  // Result register: holds up to two results and hands them out in order.
  cstr_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .pair_i  (pair),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {res.line, res.data};
  assign m_axis_tuser_o = res.kind;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !advance |=> in_v_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("registered request lost before it was scanned");

endmodule
